FILE: hdl/tsn_pkg.sv
// package: item types, event codes and fixed-point constants for the telemetry node
`timescale 1ns / 1ps
`default_nettype none

package tsn_pkg;

  localparam int unsigned FractionBits = 16;
  localparam int unsigned AdcW         = 10;
  localparam int unsigned AccW         = AdcW + FractionBits + 1;
  localparam int unsigned GainW        = 16;
  localparam int unsigned CountW       = 16;

  localparam logic [GainW-1:0] GainReset = 16'd3277;
  localparam logic [7:0]       TxPad     = 8'hFF;
  localparam logic [2:0]       TxLen     = 3'd4;
  localparam logic [1:0]       RxLen     = 2'd2;

  typedef enum logic [1:0] {
    OpBus  = 2'd0,
    OpAdc  = 2'd1,
    OpTach = 2'd2,
    OpTick = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BusAddrWr  = 3'd0,
    BusByteRx  = 3'd1,
    BusStop    = 3'd2,
    BusAddrRd  = 3'd3,
    BusTxAck   = 3'd4,
    BusTxNack  = 3'd5,
    BusLastAck = 3'd6,
    BusError   = 3'd7
  } bus_status_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [2:0]      bus_status;
    logic [7:0]      bus_data;
    logic [AdcW-1:0] adc_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic [7:0]        heater_duty;
    logic [7:0]        fan_duty;
    logic              duty_update;
    logic              bus_recover;
    logic [AdcW-1:0]   filtered_level;
    logic [CountW-1:0] pulses_per_second;
  } out_item_t;

  // result fields owned by the bus side
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] heater_duty;
    logic [7:0] fan_duty;
    logic       duty_update;
    logic       bus_recover;
  } bus_res_t;

endpackage

`default_nettype wire

FILE: hdl/tsn_bus.sv
// bus side: command frame capture, duty registers and telemetry read-out
`timescale 1ns / 1ps
`default_nettype none

module tsn_bus (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [2:0]                   status_i,
  input  wire logic [7:0]                   data_i,
  input  wire logic [tsn_pkg::AdcW-1:0]     level_i,
  input  wire logic [tsn_pkg::CountW-1:0]   pulses_i,
  output tsn_pkg::bus_res_t                 res_o
);
  import tsn_pkg::*;

  logic [1:0] rx_count_q, rx_count_d;
  logic [2:0] tx_count_q, tx_count_d;
  logic [7:0] heater_q, heater_d;
  logic [7:0] fan_q, fan_d;
  logic [7:0] rx_store_q [2];
  logic [7:0] tx_store_q [4];
  logic       rx_we;
  logic       tx_we;

  always_comb begin
    rx_count_d      = rx_count_q;
    tx_count_d      = tx_count_q;
    heater_d        = heater_q;
    fan_d           = fan_q;
    rx_we           = 1'b0;
    tx_we           = 1'b0;
    res_o.tx_byte     = 8'd0;
    res_o.tx_valid    = 1'b0;
    res_o.duty_update = 1'b0;
    res_o.bus_recover = 1'b0;
    if (en_i) begin
      unique case (bus_status_e'(status_i))
        BusAddrWr: begin
          rx_count_d = 2'd0;
        end
        BusByteRx: begin
          if (rx_count_q < RxLen) begin
            rx_we      = 1'b1;
            rx_count_d = rx_count_q + 2'd1;
          end
        end
        BusStop: begin
          // count is kept, so a repeated stop applies the frame again
          if (rx_count_q == RxLen) begin
            heater_d          = rx_store_q[0];
            fan_d             = rx_store_q[1];
            res_o.duty_update = 1'b1;
          end
        end
        BusAddrRd: begin
          tx_we          = 1'b1;
          tx_count_d     = 3'd1;
          res_o.tx_byte  = level_i[7:0];
          res_o.tx_valid = 1'b1;
        end
        BusTxAck: begin
          if (tx_count_q < TxLen) begin
            res_o.tx_byte = tx_store_q[tx_count_q[1:0]];
            tx_count_d    = tx_count_q + 3'd1;
          end else begin
            res_o.tx_byte = TxPad;
          end
          res_o.tx_valid = 1'b1;
        end
        BusTxNack, BusLastAck: begin
        end
        BusError: begin
          res_o.bus_recover = 1'b1;
        end
      endcase
    end
    res_o.heater_duty = heater_d;
    res_o.fan_duty    = fan_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_count_q <= 2'd0;
      tx_count_q <= 3'd0;
      heater_q   <= 8'd0;
      fan_q      <= 8'd0;
    end else begin
      rx_count_q <= rx_count_d;
      tx_count_q <= tx_count_d;
      heater_q   <= heater_d;
      fan_q      <= fan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_store_q[rx_count_q[0]] <= data_i;
    end
  end

  // little-endian snapshot: level then tach count
  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_store_q[0] <= level_i[7:0];
      tx_store_q[1] <= {{(16 - AdcW){1'b0}}, level_i[AdcW-1:8]};
      tx_store_q[2] <= pulses_i[7:0];
      tx_store_q[3] <= pulses_i[15:8];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tsn_filter.sv
// adc smoothing: exponential average in signed fixed point and biased, rounded level
`timescale 1ns / 1ps
`default_nettype none

module tsn_filter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [tsn_pkg::AdcW-1:0]    code_i,
  input  wire logic [tsn_pkg::GainW-1:0]   gain_i,
  output      logic [tsn_pkg::AdcW-1:0]    level_o
);
  import tsn_pkg::*;

  localparam int unsigned ProdW = AccW + 1 + GainW + 1;
  localparam logic signed [ProdW-1:0] Half = ProdW'(1) <<< (GainW - 1);
  localparam logic signed [AccW:0] Bias =
    ((AccW + 1)'(1) <<< (FractionBits + AdcW - 1)) + ((AccW + 1)'(1) <<< (FractionBits - 1));

  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    seeded_q;
  logic [AdcW-1:0]         level_q, level_d;
  logic signed [AccW-1:0]  target;
  logic signed [AccW:0]    diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] step;
  logic signed [AccW:0]    biased;

  assign target = {code_i[AdcW-1], code_i, {FractionBits{1'b0}}};
  assign diff   = {target[AccW-1], target} - {acc_q[AccW-1], acc_q};
  assign prod   = $signed(diff) * $signed({1'b0, gain_i});
  // round half up, then floor shift back to the accumulator scale
  assign step   = (prod + Half) >>> GainW;

  always_comb begin
    acc_d = acc_q;
    if (en_i) begin
      if (seeded_q) begin
        acc_d = acc_q + step[AccW-1:0];
      end else begin
        acc_d = target;
      end
    end
    biased  = {acc_d[AccW-1], acc_d} + Bias;
    level_d = en_i ? biased[FractionBits +: AdcW] : level_q;
  end

  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      seeded_q <= 1'b0;
      level_q  <= '0;
    end else begin
      acc_q   <= acc_d;
      level_q <= level_d;
      if (en_i) begin
        seeded_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tsn_tach.sv
// tach pulse counter with once-a-second latch and clear
`timescale 1ns / 1ps
`default_nettype none

module tsn_tach (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         pulse_i,
  input  wire logic                         tick_i,
  output      logic [tsn_pkg::CountW-1:0]   latched_o
);
  import tsn_pkg::*;

  logic [CountW-1:0] live_q, live_d;
  logic [CountW-1:0] latched_q, latched_d;

  always_comb begin
    live_d    = live_q;
    latched_d = latched_q;
    if (tick_i) begin
      latched_d = live_q;
      live_d    = '0;
    end else if (pulse_i) begin
      live_d = live_q + CountW'(1);
    end
  end

  assign latched_o = latched_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      latched_q <= '0;
    end else begin
      live_q    <= live_d;
      latched_q <= latched_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/telemetry_i2c_slave_node_core.sv
// top level: input register, event units and two-entry result queue
// path: an accepted item passes the input register, then the queue, before it shows at the output
// throughput: one item per cycle; the two-entry result queue keeps input open while a result waits
// a full queue with a loaded input register holds ready low until the output side takes an item
// reset: asynchronous active low; counts, duties, average, level and tach clear, gain returns to
// 3277; the receive and transmit byte stores are not cleared
`timescale 1ns / 1ps
`default_nettype none

module telemetry_i2c_slave_node_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire tsn_pkg::in_item_t           in_item_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      tsn_pkg::out_item_t          out_item_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tsn_pkg::GainW-1:0]   cfg_wdata_i
);
  import tsn_pkg::*;

  logic [GainW-1:0]  gain_q;
  logic              s1_valid_q;
  in_item_t          s1_item_q;
  logic              s1_fire;
  logic              fifo_full;
  logic              push;
  logic              pop;
  logic [1:0]        count_q;
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  out_item_t         fifo_q [2];
  out_item_t         res;
  bus_res_t          bus_res;
  logic [AdcW-1:0]   level;
  logic [CountW-1:0] pulses;
  op_e               op;

  assign fifo_full  = (count_q == 2'd2);
  assign s1_fire    = s1_valid_q && !fifo_full;
  assign in_ready_o = !s1_valid_q || !fifo_full;
  assign push       = s1_fire;
  assign pop        = out_valid_o && out_ready_i;
  assign op         = op_e'(s1_item_q.op);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  tsn_bus u_bus (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_fire && (op == OpBus)),
    .status_i (s1_item_q.bus_status),
    .data_i   (s1_item_q.bus_data),
    .level_i  (level),
    .pulses_i (pulses),
    .res_o    (bus_res)
  );

  tsn_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_fire && (op == OpAdc)),
    .code_i  (s1_item_q.adc_code),
    .gain_i  (gain_q),
    .level_o (level)
  );

  tsn_tach u_tach (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pulse_i   (s1_fire && (op == OpTach)),
    .tick_i    (s1_fire && (op == OpTick)),
    .latched_o (pulses)
  );

  always_comb begin
    res.tx_byte           = bus_res.tx_byte;
    res.tx_valid          = bus_res.tx_valid;
    res.heater_duty       = bus_res.heater_duty;
    res.fan_duty          = bus_res.fan_duty;
    res.duty_update       = bus_res.duty_update;
    res.bus_recover       = bus_res.bus_recover;
    res.filtered_level    = level;
    res.pulses_per_second = pulses;
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = fifo_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && fifo_full && !pop |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled item lost from input register");

  a_recover_bus_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.bus_recover |-> op == OpBus && s1_item_q.bus_status == BusError)
    else $error("recovery flag on a non-error item");

  a_tx_bus_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.tx_valid |-> op == OpBus)
    else $error("transmit byte on a non-bus item");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire
